FILE: hw/rtl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

	// input field widths
	localparam int HUE_W = 16;
	localparam int PCT_W = 8;

	// clamped percentage 0..100
	typedef logic [6:0] pct_t;
	// product of two percentages, 0..10000
	typedef logic [13:0] pct_prod_t;
	// hue reduced to 0..359
	typedef logic [8:0] deg_t;
	// tent factor 0..60 for the secondary
	typedef logic [5:0] frac_t;
	// channel level in units of 1/600000
	typedef logic [19:0] chan_t;
	localparam int CHAN_W = 20;

	localparam pct_t PCT_MAX = 7'd100;
	localparam deg_t DEG_FULL = 9'd360;
	localparam frac_t SEXT_DEG = 6'd60;

	// sextant start points
	localparam deg_t SEXT_B1 = 9'd60;
	localparam deg_t SEXT_B2 = 9'd120;
	localparam deg_t SEXT_B3 = 9'd180;
	localparam deg_t SEXT_B4 = 9'd240;
	localparam deg_t SEXT_B5 = 9'd300;

	// hue / 360 by reciprocal: floor(h * 11651 / 2^22) is exact for 16-bit h
	localparam logic [13:0] HUE_RECIP = 14'd11651;
	localparam int HUE_RECIP_SH = 22;

	// half of full scale, rounding offset
	localparam chan_t HALF_SCALE = 20'd300000;

	// n / 600000 = (n >> 6) / 9375; the latter by reciprocal
	// ceil(2^44 / 9375), exact for a 30-bit dividend
	localparam int DIV_PRE_SH = 6;
	localparam int RECIP_W = 31;
	localparam logic [30:0] DIV_RECIP = 31'd1876499845;
	localparam int RECIP_SH = 44;

	// 60-degree sextant of the hue
	typedef enum logic [2:0] {
		SEXT_RED_YEL,
		SEXT_YEL_GRN,
		SEXT_GRN_CYN,
		SEXT_CYN_BLU,
		SEXT_BLU_MAG,
		SEXT_MAG_RED
	} sext_t;

	// load enables of the scaling stages
	typedef struct packed {
		logic ld_s6;
		logic ld_s7;
	} scale_ctl_t;

endpackage

FILE: hw/rtl/hsv2rgb_scale.sv
// Scales one channel level (units of 1/600000) to a rounded code.
module hsv2rgb_scale #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                        clk,
	input  hsv2rgb_pkg::scale_ctl_t     ctl,
	input  hsv2rgb_pkg::chan_t          level,
	output logic [CHANNEL_BITS-1:0]     code
);

	localparam int NUM_W = hsv2rgb_pkg::CHAN_W + CHANNEL_BITS;
	localparam int SHR_W = NUM_W - hsv2rgb_pkg::DIV_PRE_SH;
	localparam int PROD_W = SHR_W + hsv2rgb_pkg::RECIP_W;
	localparam logic [CHANNEL_BITS-1:0] CODE_MAX = '1;

	logic [NUM_W-1:0]        num_s6;
	logic [PROD_W-1:0]       quo_prod;
	logic [CHANNEL_BITS-1:0] code_s7;

	// level * code_max + half scale
	always_ff @(posedge clk) begin
		if (ctl.ld_s6) begin
			num_s6 <= NUM_W'(level) * NUM_W'(CODE_MAX) + NUM_W'(hsv2rgb_pkg::HALF_SCALE);
		end
	end

	// divide by full scale through the reciprocal
	assign quo_prod = PROD_W'(num_s6[NUM_W-1:hsv2rgb_pkg::DIV_PRE_SH])
		* PROD_W'(hsv2rgb_pkg::DIV_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.ld_s7) begin
			code_s7 <= quo_prod[hsv2rgb_pkg::RECIP_SH +: CHANNEL_BITS];
		end
	end

	assign code = code_s7;

endmodule

FILE: hw/rtl/hsv_to_rgb_converter_top.sv
// HSV to RGB converter. One colour word enters and one RGB word leaves per
// clock unless the output stalls. Seven register stages: hue quotient by 360
// and percentage clamp, hue remainder and v*s products, sextant and tent
// factor, chroma/secondary/offset products, channel sums, and two
// multiplier stages scaling each channel to a code rounded to nearest (ties
// up). Hue may be any 16-bit value; saturation and value above 100 read as
// 100. A stall on the output freezes only full stages, so bubbles close up.
module hsv_to_rgb_converter_top #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    hsv_valid,
	output logic                    hsv_stall,
	input  logic [15:0]             hue_deg,
	input  logic [7:0]              sat_pct,
	input  logic [7:0]              val_pct,
	output logic                    rgb_valid,
	input  logic                    rgb_stall,
	output logic [CHANNEL_BITS-1:0] red_code,
	output logic [CHANNEL_BITS-1:0] green_code,
	output logic [CHANNEL_BITS-1:0] blue_code
);

	localparam int NSTAGE = 7;

	logic [NSTAGE:1] vld_q;
	logic [NSTAGE:1] ld;

	// stage 1
	logic [29:0]                hue_prod;
	logic [15:0]                hue_s1;
	logic [7:0]                 quo_s1;
	hsv2rgb_pkg::pct_t          sat_s1, val_s1;
	// stage 2
	logic [15:0]                rem_full;
	hsv2rgb_pkg::deg_t          hdeg_s2;
	hsv2rgb_pkg::pct_prod_t     vs_s2, vm_s2;
	// stage 3
	hsv2rgb_pkg::sext_t         sext_c;
	hsv2rgb_pkg::deg_t          base_c;
	hsv2rgb_pkg::deg_t          off_full;
	hsv2rgb_pkg::frac_t         off_c;
	hsv2rgb_pkg::sext_t         sext_s3;
	hsv2rgb_pkg::frac_t         frac_s3;
	hsv2rgb_pkg::pct_prod_t     vs_s3, vm_s3;
	// stage 4
	hsv2rgb_pkg::sext_t         sext_s4;
	hsv2rgb_pkg::chan_t         c_s4, x_s4, m_s4;
	// stage 5
	hsv2rgb_pkg::chan_t         r_c, g_c, b_c;
	hsv2rgb_pkg::chan_t         r_s5, g_s5, b_s5;
	hsv2rgb_pkg::scale_ctl_t    sctl;

	// stage loads: a stage takes a word when empty or when it moves on
	always_comb begin
		ld[NSTAGE] = !vld_q[NSTAGE] || !rgb_stall;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	assign hsv_stall = !ld[1];
	assign rgb_valid = vld_q[NSTAGE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[1]) begin
				vld_q[1] <= hsv_valid;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// S1: quotient of hue by 360, clamp percentages
	assign hue_prod = 30'(hue_deg) * 30'(hsv2rgb_pkg::HUE_RECIP);

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			hue_s1 <= hue_deg;
			quo_s1 <= hue_prod[hsv2rgb_pkg::HUE_RECIP_SH +: 8];
			sat_s1 <= (sat_pct > 8'(hsv2rgb_pkg::PCT_MAX)) ? hsv2rgb_pkg::PCT_MAX
				: sat_pct[6:0];
			val_s1 <= (val_pct > 8'(hsv2rgb_pkg::PCT_MAX)) ? hsv2rgb_pkg::PCT_MAX
				: val_pct[6:0];
		end
	end

	// S2: hue remainder, v*s and v*(100-s)
	assign rem_full = hue_s1 - 16'(quo_s1) * 16'(hsv2rgb_pkg::DEG_FULL);

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			hdeg_s2 <= rem_full[8:0];
			vs_s2   <= 14'(val_s1) * 14'(sat_s1);
			vm_s2   <= 14'(val_s1) * 14'(hsv2rgb_pkg::PCT_MAX - sat_s1);
		end
	end

	// S3: sextant and tent factor (60 - distance from the peak)
	always_comb begin
		priority if (hdeg_s2 >= hsv2rgb_pkg::SEXT_B5) begin
			sext_c = hsv2rgb_pkg::SEXT_MAG_RED;
			base_c = hsv2rgb_pkg::SEXT_B5;
		end else if (hdeg_s2 >= hsv2rgb_pkg::SEXT_B4) begin
			sext_c = hsv2rgb_pkg::SEXT_BLU_MAG;
			base_c = hsv2rgb_pkg::SEXT_B4;
		end else if (hdeg_s2 >= hsv2rgb_pkg::SEXT_B3) begin
			sext_c = hsv2rgb_pkg::SEXT_CYN_BLU;
			base_c = hsv2rgb_pkg::SEXT_B3;
		end else if (hdeg_s2 >= hsv2rgb_pkg::SEXT_B2) begin
			sext_c = hsv2rgb_pkg::SEXT_GRN_CYN;
			base_c = hsv2rgb_pkg::SEXT_B2;
		end else if (hdeg_s2 >= hsv2rgb_pkg::SEXT_B1) begin
			sext_c = hsv2rgb_pkg::SEXT_YEL_GRN;
			base_c = hsv2rgb_pkg::SEXT_B1;
		end else begin
			sext_c = hsv2rgb_pkg::SEXT_RED_YEL;
			base_c = '0;
		end
		off_full = hdeg_s2 - base_c;
		off_c    = off_full[5:0];
	end

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			sext_s3 <= sext_c;
			// rising edge of the tent in even sextants, falling in odd ones
			frac_s3 <= sext_c[0] ? (hsv2rgb_pkg::SEXT_DEG - off_c) : off_c;
			vs_s3   <= vs_s2;
			vm_s3   <= vm_s2;
		end
	end

	// S4: chroma, secondary and offset
	always_ff @(posedge clk) begin
		if (ld[4]) begin
			sext_s4 <= sext_s3;
			c_s4    <= 20'(vs_s3) * 20'(hsv2rgb_pkg::SEXT_DEG);
			x_s4    <= 20'(vs_s3) * 20'(frac_s3);
			m_s4    <= 20'(vm_s3) * 20'(hsv2rgb_pkg::SEXT_DEG);
		end
	end

	// S5: place c and x on the channels, add the offset
	always_comb begin
		unique case (sext_s4)
			hsv2rgb_pkg::SEXT_RED_YEL: begin
				r_c = c_s4; g_c = x_s4; b_c = '0;
			end
			hsv2rgb_pkg::SEXT_YEL_GRN: begin
				r_c = x_s4; g_c = c_s4; b_c = '0;
			end
			hsv2rgb_pkg::SEXT_GRN_CYN: begin
				r_c = '0; g_c = c_s4; b_c = x_s4;
			end
			hsv2rgb_pkg::SEXT_CYN_BLU: begin
				r_c = '0; g_c = x_s4; b_c = c_s4;
			end
			hsv2rgb_pkg::SEXT_BLU_MAG: begin
				r_c = x_s4; g_c = '0; b_c = c_s4;
			end
			hsv2rgb_pkg::SEXT_MAG_RED: begin
				r_c = c_s4; g_c = '0; b_c = x_s4;
			end
			default: begin
				r_c = c_s4; g_c = '0; b_c = x_s4;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			r_s5 <= r_c + m_s4;
			g_s5 <= g_c + m_s4;
			b_s5 <= b_c + m_s4;
		end
	end

	// S6, S7: code scaling per channel
	assign sctl.ld_s6 = ld[6];
	assign sctl.ld_s7 = ld[7];

	hsv2rgb_scale #(.CHANNEL_BITS(CHANNEL_BITS)) u_scale_red (
		.clk   (clk),
		.ctl   (sctl),
		.level (r_s5),
		.code  (red_code)
	);

	hsv2rgb_scale #(.CHANNEL_BITS(CHANNEL_BITS)) u_scale_green (
		.clk   (clk),
		.ctl   (sctl),
		.level (g_s5),
		.code  (green_code)
	);

	hsv2rgb_scale #(.CHANNEL_BITS(CHANNEL_BITS)) u_scale_blue (
		.clk   (clk),
		.ctl   (sctl),
		.level (b_s5),
		.code  (blue_code)
	);

endmodule

FILE: hw/rtl/hsv2rgb_check.sv
// Port-level checks for the converter.
module hsv2rgb_check #(
	parameter int CHANNEL_BITS = 8
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    hsv_valid,
	input logic                    hsv_stall,
	input logic                    rgb_valid,
	input logic                    rgb_stall,
	input logic [CHANNEL_BITS-1:0] red_code,
	input logic [CHANNEL_BITS-1:0] green_code,
	input logic [CHANNEL_BITS-1:0] blue_code
);

	// a stalled word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && rgb_stall |=> rgb_valid)
		else $error("output word dropped under stall");

	// a stalled payload holds
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && rgb_stall |=>
			$stable(red_code) && $stable(green_code) && $stable(blue_code))
		else $error("output payload changed under stall");

	// input back-pressure only comes from a full, stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_stall |-> rgb_valid && rgb_stall)
		else $error("input stalled while output free");

	// free-flowing pipe: every word taken at the input comes out, none is lost or invented
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3) &&
		$past(arst_n, 4) && $past(arst_n, 5) && $past(arst_n, 6) &&
		$past(arst_n, 7) && !$past(hsv_stall, 7) &&
		!$past(rgb_stall, 1) && !$past(rgb_stall, 2) && !$past(rgb_stall, 3) &&
		!$past(rgb_stall, 4) && !$past(rgb_stall, 5) && !$past(rgb_stall, 6)
		|-> rgb_valid == $past(hsv_valid, 7))
		else $error("word lost or invented in pipeline");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_check #(.CHANNEL_BITS(CHANNEL_BITS)) u_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.hsv_valid  (hsv_valid),
	.hsv_stall  (hsv_stall),
	.rgb_valid  (rgb_valid),
	.rgb_stall  (rgb_stall),
	.red_code   (red_code),
	.green_code (green_code),
	.blue_code  (blue_code)
);

FILE: sim/tb_hsv_to_rgb_converter_top.sv
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter_top;

	localparam int CHANNEL_BITS = 8;
	localparam longint unsigned FULL_SCALE = 600000;
	localparam longint unsigned CODE_MAX = (64'd1 << CHANNEL_BITS) - 1;
	localparam int IDLE_PCT = 38;
	localparam int DRAIN_CYCLES = 16;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
	} rgb_word_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    hsv_valid = 1'b0;
	logic                    hsv_stall;
	logic [15:0]             hue_deg = '0;
	logic [7:0]              sat_pct = '0;
	logic [7:0]              val_pct = '0;
	logic                    rgb_valid;
	logic                    rgb_stall = 1'b0;
	logic [CHANNEL_BITS-1:0] red_code;
	logic [CHANNEL_BITS-1:0] green_code;
	logic [CHANNEL_BITS-1:0] blue_code;

	// colours still owed by the converter, oldest first
	rgb_word_t pending_rgb[$];
	int        mismatch_count = 0;
	int        stall_run = 0;
	bit        steady = 1'b0;

	hsv_to_rgb_converter_top #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_stall (hsv_stall),
		.hue_deg   (hue_deg),
		.sat_pct   (sat_pct),
		.val_pct   (val_pct),
		.rgb_valid (rgb_valid),
		.rgb_stall (rgb_stall),
		.red_code  (red_code),
		.green_code(green_code),
		.blue_code (blue_code)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// channel level (units of 1/600000) to a code, round to nearest, ties up
	function automatic logic [CHANNEL_BITS-1:0] level_to_code(input int unsigned lvl);
		longint unsigned num;
		num = lvl * CODE_MAX * 2 + FULL_SCALE;
		return CHANNEL_BITS'(num / (2 * FULL_SCALE));
	endfunction

	function automatic rgb_word_t hsv_colour_to_rgb(input logic [15:0] hue,
			input logic [7:0] sat, input logic [7:0] val);
		hsv2rgb_pkg::deg_t h;
		int unsigned s, v, t, peak_dist, chroma, second, offset;
		int unsigned lvl_r, lvl_g, lvl_b;
		rgb_word_t   w;
		h = hsv2rgb_pkg::deg_t'(hue % hsv2rgb_pkg::DEG_FULL);
		s = (sat > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX : sat;
		v = (val > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX : val;
		// tent shape: distance of (h mod 120) from 60
		t = h % (2 * hsv2rgb_pkg::SEXT_DEG);
		peak_dist = (t >= hsv2rgb_pkg::SEXT_DEG) ? (t - hsv2rgb_pkg::SEXT_DEG)
			: (hsv2rgb_pkg::SEXT_DEG - t);
		chroma = v * s * hsv2rgb_pkg::SEXT_DEG;
		second = v * s * (hsv2rgb_pkg::SEXT_DEG - peak_dist);
		offset = v * hsv2rgb_pkg::SEXT_DEG * (hsv2rgb_pkg::PCT_MAX - s);
		case (hsv2rgb_pkg::sext_t'(3'(h / hsv2rgb_pkg::SEXT_DEG)))
			hsv2rgb_pkg::SEXT_RED_YEL: begin
				lvl_r = chroma; lvl_g = second; lvl_b = 0;
			end
			hsv2rgb_pkg::SEXT_YEL_GRN: begin
				lvl_r = second; lvl_g = chroma; lvl_b = 0;
			end
			hsv2rgb_pkg::SEXT_GRN_CYN: begin
				lvl_r = 0; lvl_g = chroma; lvl_b = second;
			end
			hsv2rgb_pkg::SEXT_CYN_BLU: begin
				lvl_r = 0; lvl_g = second; lvl_b = chroma;
			end
			hsv2rgb_pkg::SEXT_BLU_MAG: begin
				lvl_r = second; lvl_g = 0; lvl_b = chroma;
			end
			default: begin
				lvl_r = chroma; lvl_g = 0; lvl_b = second;
			end
		endcase
		w.red = level_to_code(lvl_r + offset);
		w.green = level_to_code(lvl_g + offset);
		w.blue = level_to_code(lvl_b + offset);
		return w;
	endfunction

	// offer one HSV word, hold it until taken, then log the colour it owes
	task automatic send_colour(input logic [15:0] hue, input logic [7:0] sat,
			input logic [7:0] val);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			hsv_valid <= 1'b0;
		end
		@(negedge clk);
		hsv_valid <= 1'b1;
		hue_deg <= hue;
		sat_pct <= sat;
		val_pct <= val;
		do
			@(posedge clk);
		while (!(hsv_valid && !hsv_stall));
		pending_rgb.push_back(hsv_colour_to_rgb(hue, sat, val));
	endtask

	function automatic logic [7:0] random_pct();
		// mostly in range, sometimes above 100 to hit the clamp
		if ($urandom_range(99) < 80)
			return 8'($urandom_range(100));
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [15:0] random_hue();
		case ($urandom_range(3))
			0:       return 16'($urandom_range(359));
			// just either side of a sextant edge, possibly many turns up
			1:       return 16'($urandom_range(5) * 60 + $urandom_range(2) - 1
			               + 360 * $urandom_range(180));
			default: return 16'($urandom);
		endcase
	endfunction

	// receiver back-pressure: random stalls plus the odd long hold
	always @(negedge clk) begin
		if (steady) begin
			rgb_stall <= 1'b0;
		end else if (stall_run > 0) begin
			stall_run <= stall_run - 1;
			rgb_stall <= 1'b1;
		end else if ($urandom_range(99) < 2) begin
			stall_run <= $urandom_range(20, 8);
			rgb_stall <= 1'b1;
		end else begin
			rgb_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	// compare each RGB word taken against the oldest owed colour
	always @(posedge clk) begin : check_rgb
		rgb_word_t want;
		if (arst_n && rgb_valid && !rgb_stall) begin
			if (pending_rgb.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected RGB word r=%0d g=%0d b=%0d",
						red_code, green_code, blue_code);
			end else begin
				want = pending_rgb.pop_front();
				if (red_code !== want.red || green_code !== want.green
						|| blue_code !== want.blue) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("RGB mismatch: exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
							want.red, want.green, want.blue,
							red_code, green_code, blue_code);
				end
			end
		end
	end

	// corners: sextant edges, top of hue range, clamped percentages, greys
	task automatic test_directed();
		send_colour(16'd0, 8'd100, 8'd100);
		send_colour(16'd60, 8'd100, 8'd100);
		send_colour(16'd120, 8'd100, 8'd100);
		send_colour(16'd180, 8'd100, 8'd100);
		send_colour(16'd240, 8'd100, 8'd100);
		send_colour(16'd300, 8'd100, 8'd100);
		send_colour(16'd359, 8'd100, 8'd100);
		send_colour(16'd360, 8'd100, 8'd100);
		send_colour(16'd65535, 8'd100, 8'd100);
		send_colour(16'd65535, 8'd255, 8'd255);
		send_colour(16'd30, 8'd0, 8'd0);
		send_colour(16'd30, 8'd0, 8'd100);
		send_colour(16'd30, 8'd0, 8'd50);
		send_colour(16'd90, 8'd101, 8'd101);
		send_colour(16'd210, 8'd255, 8'd100);
		send_colour(16'd270, 8'd100, 8'd255);
		send_colour(16'd330, 8'd50, 8'd50);
		send_colour(16'd719, 8'd1, 8'd1);
		send_colour(16'd45, 8'd33, 8'd67);
		send_colour(16'd32768, 8'd128, 8'd127);
		send_colour(16'd150, 8'd100, 8'd1);
		send_colour(16'd1, 8'd99, 8'd99);
	endtask

	task automatic test_random_colours(input int count);
		repeat (count)
			send_colour(random_hue(), random_pct(), random_pct());
	endtask

	// back-to-back words with neither side idling
	task automatic test_steady_stream(input int count);
		steady = 1'b1;
		repeat (count)
			send_colour(random_hue(), random_pct(), random_pct());
		steady = 1'b0;
	endtask

	// edges of every sextant at assorted brightness and saturation
	task automatic test_sextant_edges();
		int k;
		for (k = 0; k < 60; k++)
			send_colour(16'(60 * (k % 6) + $urandom_range(2) - 1 + 360 * (k % 3)),
				random_pct(), random_pct());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_colours(400);
		test_sextant_edges();
		test_steady_stream(200);
		test_random_colours(140);
		@(negedge clk);
		hsv_valid <= 1'b0;
		wait (pending_rgb.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_rgb.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// hang guard
	initial begin
		#(3_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
